@@ hw/rtl/vfr_pkg.sv @@
package vfr_pkg;

	// Field widths fixed by the stream format.
	localparam int IDX_W = 16;
	localparam int CNT_W = 17;

	// Default table depth and reset value of the vertex count register.
	localparam int VERTEX_MAX_DEF = 65536;
	localparam logic [CNT_W-1:0] VCOUNT_RESET = 17'd65536;

	// Mesh epoch tag stored beside every table entry. Tag zero is never live.
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = 8'hFF;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_WR2
	} vfr_state_t;

	typedef struct packed {
		logic accept;    // capture the item and read both tables
		logic load_res;  // load the result register
		logic wr1;       // first table writes, advance the next free number
		logic wr2;       // second forward table write
		logic new_mesh;  // move to a new epoch, next free number to zero
		logic clr;       // write one entry of the clearing pass
	} vfr_cmd_t;

	typedef struct packed {
		logic first;      // item is in range and its vertex is seen the first time
		logic last;       // item carries the last mark
		logic epoch_max;  // epoch counter is at its top value
		logic clr_done;   // clearing pass is at its final entry
		logic out_free;   // result register can take a new result
	} vfr_status_t;

endpackage

@@ hw/rtl/vfr_ifs.sv @@
interface vfr_index_if;
	logic valid;
	logic ready;
	logic [vfr_pkg::IDX_W-1:0] old_index;
	logic last_index;

	modport source (output valid, output old_index, output last_index, input ready);
	modport sink (input valid, input old_index, input last_index, output ready);
endinterface

interface vfr_result_if;
	logic valid;
	logic ready;
	logic [vfr_pkg::IDX_W-1:0] new_index;
	logic swap_needed;
	logic [vfr_pkg::IDX_W-1:0] swap_from;
	logic out_of_range;
	logic last_out;

	modport source (output valid, output new_index, output swap_needed, output swap_from,
		output out_of_range, output last_out, input ready);
	modport sink (input valid, input new_index, input swap_needed, input swap_from,
		input out_of_range, input last_out, output ready);
endinterface

@@ hw/rtl/vfr_ctrl.sv @@
module vfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vfr_pkg::vfr_status_t sts,
	output vfr_pkg::vfr_cmd_t    cmd
);
	import vfr_pkg::*;

	vfr_state_t state_q;
	vfr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.load_res = 1'b1;
					if (sts.first) begin
						cmd.wr1 = 1'b1;
						state_d = ST_WR2;
					end else if (sts.last) begin
						cmd.new_mesh = 1'b1;
						state_d      = sts.epoch_max ? ST_CLEAR : ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WR2: begin
				cmd.wr2 = 1'b1;
				if (sts.last) begin
					cmd.new_mesh = 1'b1;
					state_d      = sts.epoch_max ? ST_CLEAR : ST_IDLE;
				end else begin
					// The datapath forwards this write to a read issued at the same edge.
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_DECIDE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/vfr_dp.sv @@
module vfr_dp #(
	parameter int VERTEX_MAX = vfr_pkg::VERTEX_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [vfr_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic [vfr_pkg::IDX_W-1:0]  old_index,
	input  logic                       last_index,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [vfr_pkg::IDX_W-1:0]  new_index,
	output logic                       swap_needed,
	output logic [vfr_pkg::IDX_W-1:0]  swap_from,
	output logic                       out_of_range,
	output logic                       last_out,
	input  vfr_pkg::vfr_cmd_t          cmd,
	output vfr_pkg::vfr_status_t       sts
);
	import vfr_pkg::*;

	localparam int AW  = $clog2(VERTEX_MAX);
	localparam int NFW = $clog2(VERTEX_MAX + 1);
	localparam int DW  = EPOCH_W + AW;
	localparam logic [CNT_W-1:0] VMAX_CNT = CNT_W'(VERTEX_MAX);
	localparam logic [NFW-1:0]   VMAX_NF  = NFW'(VERTEX_MAX);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(VERTEX_MAX - 1);

	// Each entry holds {epoch tag, value}. A tag other than the live epoch
	// means the entry still holds its identity value.
	logic [DW-1:0] fwd_mem [VERTEX_MAX];
	logic [DW-1:0] inv_mem [VERTEX_MAX];

	logic [CNT_W-1:0]   vcount_q;
	logic [NFW-1:0]     nf_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      clr_cnt_q;

	logic [AW-1:0] oldi_q;
	logic [AW-1:0] iaddr_q;
	logic          last_q;
	logic          oor_q;
	logic [DW-1:0] frd_q;
	logic [DW-1:0] ird_q;
	logic [AW-1:0] wr2_addr_q;
	logic [AW-1:0] wr2_data_q;

	logic                res_valid_q;
	logic [IDX_W-1:0]    new_index_q;
	logic                swap_needed_q;
	logic [IDX_W-1:0]    swap_from_q;
	logic                oor_res_q;
	logic                last_res_q;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] slot;
	logic [AW-1:0] other;
	logic [AW-1:0] nw;
	logic          first;
	logic          swap;
	logic          out_free;

	logic          f_we;
	logic [AW-1:0] f_waddr;
	logic [DW-1:0] f_wdata;
	logic          i_we;
	logic [AW-1:0] i_waddr;
	logic [DW-1:0] i_wdata;

	assign rd_addr = old_index[AW-1:0];
	assign nw      = nf_q[AW-1:0];
	assign slot    = (frd_q[DW-1:AW] == epoch_q) ? frd_q[AW-1:0] : oldi_q;
	assign other   = (ird_q[DW-1:AW] == epoch_q) ? ird_q[AW-1:0] : iaddr_q;
	assign first   = !oor_q && (NFW'(slot) >= nf_q) && (nf_q < VMAX_NF);
	assign swap    = first && (slot != nw);
	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		sts.first     = first;
		sts.last      = last_q;
		sts.epoch_max = (epoch_q == EPOCH_LAST);
		sts.clr_done  = (clr_cnt_q == LAST_ADDR);
		sts.out_free  = out_free;
	end

	// Forward table: the first write sets the new vertex's number, the second
	// moves the displaced vertex into the vacated slot.
	always_comb begin
		f_we = cmd.clr || cmd.wr1 || cmd.wr2;
		if (cmd.clr) begin
			f_waddr = clr_cnt_q;
			f_wdata = '0;
		end else if (cmd.wr2) begin
			f_waddr = wr2_addr_q;
			f_wdata = {epoch_q, wr2_data_q};
		end else begin
			f_waddr = oldi_q;
			f_wdata = {epoch_q, nw};
		end
		i_we    = cmd.clr || cmd.wr1;
		i_waddr = cmd.clr ? clr_cnt_q : slot;
		i_wdata = cmd.clr ? '0 : {epoch_q, other};
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fwd_mem[f_waddr] <= f_wdata;
		end
		if (cmd.accept) begin
			if (cmd.wr2 && (rd_addr == wr2_addr_q)) begin
				frd_q <= {epoch_q, wr2_data_q};
			end else begin
				frd_q <= fwd_mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			inv_mem[i_waddr] <= i_wdata;
		end
		if (cmd.accept) begin
			ird_q <= inv_mem[nw];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			oldi_q  <= rd_addr;
			iaddr_q <= nw;
			last_q  <= last_index;
			oor_q   <= ({1'b0, old_index} >= vcount_q) || ({1'b0, old_index} >= VMAX_CNT);
		end
		if (cmd.wr1) begin
			wr2_addr_q <= other;
			wr2_data_q <= slot;
		end
		if (cmd.load_res) begin
			new_index_q   <= oor_q ? '0 : (first ? IDX_W'(nw) : IDX_W'(slot));
			swap_needed_q <= swap;
			swap_from_q   <= swap ? IDX_W'(slot) : '0;
			oor_res_q     <= oor_q;
			last_res_q    <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RESET;
			nf_q        <= '0;
			epoch_q     <= EPOCH_FIRST;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (cmd.new_mesh) begin
				nf_q    <= '0;
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end else if (cmd.wr1) begin
				nf_q <= nf_q + NFW'(1);
			end
			if (cmd.clr) begin
				clr_cnt_q <= (clr_cnt_q == LAST_ADDR) ? '0 : clr_cnt_q + AW'(1);
			end
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign new_index    = new_index_q;
	assign swap_needed  = swap_needed_q;
	assign swap_from    = swap_from_q;
	assign out_of_range = oor_res_q;
	assign last_out     = last_res_q;

`ifndef SYNTHESIS
	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= VMAX_NF)
		else $error("next free number beyond table depth");
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("epoch reached the cleared tag");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !cmd.accept && !cmd.load_res)
		else $error("item handled during the clearing pass");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> out_free)
		else $error("result register overwritten");
	a_mesh_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.new_mesh |=> nf_q == '0)
		else $error("next free number not cleared after last item");
`endif

endmodule

@@ hw/rtl/vertex_first_use_renumber.sv @@
// Flow: an item is taken in IDLE or WR2, and the result register loads once DECIDE finds it
// free; a result held downstream stalls the next item's decision there.
// A new item waits until the last one is decided. A first-seen vertex's second forward write
// overlaps the next item's table reads through a bypass, but not for a first-seen last item.
// Reset: asynchronous, active low; a clearing pass over all VERTEX_MAX entries follows reset, and
// another follows every 255th mesh when the epoch tag wraps. No item is taken meanwhile.
module vertex_first_use_renumber #(
	parameter int VERTEX_MAX = vfr_pkg::VERTEX_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	vfr_index_if.sink                 indices,
	vfr_result_if.source              results,
	input  logic                      cfg_wr_en,
	input  logic [vfr_pkg::CNT_W-1:0] cfg_wr_data
);
	import vfr_pkg::*;

	// The block renumbers vertices in order of first use. Two tables, each one
	// entry per vertex, hold the permutation (original vertex to slot) and its
	// inverse (slot to original vertex). Every entry carries an epoch tag, so
	// the return to identity after a last item is a single epoch step, with a sweep
	// only at an epoch wrap; an entry whose tag is stale reads as its own address.
	//
	// The controller sequences each item: accept and read both tables, then
	// decide and, for a first-seen vertex, issue the first pair of writes, then
	// the second forward write. The datapath holds the tables, the next free
	// number, the vertex count register and the result register, which lets the
	// block take a new item while a result still waits downstream.

	vfr_cmd_t    cmd;
	vfr_status_t sts;
	logic        in_ready;

	vfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (indices.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign indices.ready = in_ready;

	vfr_dp #(
		.VERTEX_MAX (VERTEX_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.old_index    (indices.old_index),
		.last_index   (indices.last_index),
		.res_valid    (results.valid),
		.res_ready    (results.ready),
		.new_index    (results.new_index),
		.swap_needed  (results.swap_needed),
		.swap_from    (results.swap_from),
		.out_of_range (results.out_of_range),
		.last_out     (results.last_out),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

@@ sim/vfr_renumber_checker.sv @@
module vfr_renumber_checker #(
	parameter int VERTEX_MAX = vfr_pkg::VERTEX_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	vfr_index_if                      indices,
	vfr_result_if                     results,
	input  logic                      cfg_wr_en,
	input  logic [vfr_pkg::CNT_W-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        pending,
	output int                        index_count,
	output int                        mesh_count,
	output int                        swap_count,
	output int                        oor_count
);
	import vfr_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] new_index;
		logic             swap_needed;
		logic [IDX_W-1:0] swap_from;
		logic             out_of_range;
		logic             last_out;
	} renumber_t;

	// Current slot of each original vertex, and the vertex that holds each slot.
	logic [IDX_W-1:0] slot_of [VERTEX_MAX];
	logic [IDX_W-1:0] vertex_in [VERTEX_MAX];
	logic [CNT_W-1:0] next_number;
	logic [CNT_W-1:0] mesh_vertices;

	// Addresses written during the current mesh, so the end of a mesh only restores those.
	logic [IDX_W-1:0] touched [$];
	renumber_t        awaited_numbers [$];

	function automatic renumber_t number_first_use(input logic [IDX_W-1:0] vtx, input logic mark);
		renumber_t        r;
		logic [CNT_W-1:0] limit;
		logic [IDX_W-1:0] slot;
		logic [IDX_W-1:0] other;
		logic [IDX_W-1:0] fresh;
		r = '0;
		r.last_out = mark;
		limit = (mesh_vertices > CNT_W'(VERTEX_MAX)) ? CNT_W'(VERTEX_MAX) : mesh_vertices;
		if ({1'b0, vtx} >= limit) begin
			r.out_of_range = 1'b1;
		end else begin
			slot = slot_of[vtx];
			if ({1'b0, slot} >= next_number && next_number < CNT_W'(VERTEX_MAX)) begin
				fresh = next_number[IDX_W-1:0];
				other = vertex_in[fresh];
				next_number = next_number + CNT_W'(1);
				slot_of[vtx] = fresh;
				slot_of[other] = slot;
				vertex_in[fresh] = vtx;
				vertex_in[slot] = other;
				touched = {touched, vtx, other, fresh, slot};
				r.new_index = fresh;
				if (slot != fresh) begin
					r.swap_needed = 1'b1;
					r.swap_from = slot;
				end
			end else begin
				r.new_index = slot;
			end
		end
		if (mark) begin
			foreach (touched[i]) begin
				slot_of[touched[i]] = touched[i];
				vertex_in[touched[i]] = touched[i];
			end
			touched.delete();
			next_number = '0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		renumber_t want;
		renumber_t got;
		if (!arst_n) begin
			for (int i = 0; i < VERTEX_MAX; i++) begin
				slot_of[i] = IDX_W'(i);
				vertex_in[i] = IDX_W'(i);
			end
			touched.delete();
			awaited_numbers.delete();
			next_number = '0;
			mesh_vertices = VCOUNT_RESET;
			fail_count = 0;
			pending = 0;
			index_count = 0;
			mesh_count = 0;
			swap_count = 0;
			oor_count = 0;
		end else begin
			if (indices.valid && indices.ready) begin
				want = number_first_use(indices.old_index, indices.last_index);
				awaited_numbers = {awaited_numbers, want};
				index_count++;
				if (want.last_out) mesh_count++;
				if (want.swap_needed) swap_count++;
				if (want.out_of_range) oor_count++;
			end
			if (results.valid && results.ready) begin
				got.new_index = results.new_index;
				got.swap_needed = results.swap_needed;
				got.swap_from = results.swap_from;
				got.out_of_range = results.out_of_range;
				got.last_out = results.last_out;
				if (awaited_numbers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result new %0d swap %b from %0d oor %b last %b",
							$time, got.new_index, got.swap_needed, got.swap_from,
							got.out_of_range, got.last_out);
				end else begin
					want = awaited_numbers.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: expected new %0d swap %b from %0d oor %b last %b",
								$time, want.new_index, want.swap_needed, want.swap_from,
								want.out_of_range, want.last_out);
							$display("%0t:      got new %0d swap %b from %0d oor %b last %b",
								$time, got.new_index, got.swap_needed, got.swap_from,
								got.out_of_range, got.last_out);
						end
					end
				end
			end
			if (cfg_wr_en) mesh_vertices = cfg_wr_data;
			pending = awaited_numbers.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
	import vfr_pkg::*;

	// The clearing pass after reset and after every epoch wrap sweeps all VERTEX_MAX entries with
	// no item taken, so the watchdog limit sits several times above its length.
	localparam int WATCHDOG_LIMIT = 300000;
	// Length of the one long hold-off on the result side, in cycles.
	localparam int LONG_HOLD = 600;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	// Idle rates in percent for both sides, changed between phases.
	int   send_idle_pct = 16;
	int   recv_idle_pct = 80;
	logic long_hold_req = 1'b0;
	int   quiet_cycles = 0;

	// The vertex count the block holds now, used to shape the random meshes.
	logic [CNT_W-1:0] count_now;

	int fail_count;
	int pending;
	int index_count;
	int mesh_count;
	int swap_count;
	int oor_count;

	// Vertex counts for the random phases, four per idle mode. Zero, one and the values
	// above the table size are all legal register contents and are covered here.
	logic [CNT_W-1:0] count_plan [12] = '{
		17'd65536, 17'd48, 17'd1, 17'd300,
		17'd131071, 17'd2, 17'd70000, 17'd0,
		17'd65535, 17'd1000, 17'd5, 17'd16
	};

	vfr_index_if  idx_ch ();
	vfr_result_if res_ch ();

	vertex_first_use_renumber dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.indices     (idx_ch),
		.results     (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	vfr_renumber_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.indices     (idx_ch),
		.results     (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.index_count (index_count),
		.mesh_count  (mesh_count),
		.swap_count  (swap_count),
		.oor_count   (oor_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The watchdog counts cycles in which neither channel moves an item. Reaching the limit
	// means the block hung, so the run ends there.
	always @(posedge clk) begin
		if ((idx_ch.valid && idx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side. Ready changes only at the falling edge. A hold-off request drops ready
	// for the length that LONG_HOLD sets, counted here, while the sender keeps pushing items so that
	// the block fills up and stalls its input.
	initial begin
		int held;
		bit hold_done;
		hold_done = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_ch.ready <= 1'b0;
				held = 0;
				while (held < LONG_HOLD) begin
					@(negedge clk);
					held++;
				end
			end else begin
				res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Offers one index and returns at the rising edge where it is taken. Valid is left high
	// on return, so back-to-back items never lower and raise it in the same step; a random
	// gap, if any, lowers it at the next falling edge instead.
	task automatic send_index(input logic [IDX_W-1:0] vtx, input logic mark);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			idx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		idx_ch.valid <= 1'b1;
		idx_ch.old_index <= vtx;
		idx_ch.last_index <= mark;
		@(posedge clk);
		while (!idx_ch.ready) @(posedge clk);
	endtask

	// Stops offering items and waits until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		idx_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// The count register is only written while the block has nothing in flight.
	task automatic write_count(input logic [CNT_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		count_now = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One mesh of random content. Real index streams reuse vertices from a small window, so
	// most indices come from such a window inside the current count; a few are arbitrary
	// 16-bit values, often out of range, and now and then a stray last mark cuts a mesh
	// short. An open mesh simply runs on into the next one.
	task automatic send_mesh(input int len, input bit closed);
		int   lim;
		int   span;
		int   base;
		logic mark;
		logic [IDX_W-1:0] vtx;
		lim = (count_now > VERTEX_MAX_DEF) ? VERTEX_MAX_DEF : int'(count_now);
		if (lim < 1) lim = 1;
		span = $urandom_range(48, 2);
		if (span > lim) span = lim;
		base = $urandom_range(lim - span, 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15, 0) == 0) vtx = IDX_W'($urandom());
			else vtx = IDX_W'(base + $urandom_range(span - 1, 0));
			mark = (closed && i == len - 1) || ($urandom_range(31, 0) == 0);
			send_index(vtx, mark);
		end
	endtask

	initial begin
		int budget;
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idx_ch.valid = 1'b0;
		idx_ch.old_index = '0;
		idx_ch.last_index = 1'b0;
		count_now = VCOUNT_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset count of 65536. Vertex 0 is first seen in its own
		// slot, 65535 needs an exchange, 0 again is already numbered, and 1 was pushed
		// out to slot 65535 by the first exchange, so it is first seen away from home.
		send_index(16'd0, 1'b0);
		send_index(16'd65535, 1'b0);
		send_index(16'd0, 1'b0);
		send_index(16'd1, 1'b0);
		send_index(16'h5555, 1'b0);
		send_index(16'hAAAA, 1'b0);
		send_index(16'd65535, 1'b0);
		send_index(16'd1, 1'b1);

		// A count of zero flags every index, the last mark included.
		write_count(17'd0);
		send_index(16'd0, 1'b0);
		send_index(16'd65535, 1'b1);

		// The smallest real mesh: only vertex 0 is in range.
		write_count(17'd1);
		send_index(16'd0, 1'b0);
		send_index(16'd1, 1'b0);
		send_index(16'd0, 1'b0);
		send_index(16'd65535, 1'b1);

		// A count beyond the table size saturates to the full table.
		write_count(17'd131071);
		send_index(16'd65535, 1'b0);
		send_index(16'd3, 1'b0);
		send_index(16'd65535, 1'b0);
		send_index(16'd0, 1'b0);

		// The count shrinks in the middle of that mesh: 65535 is numbered but is now out of
		// range, while the tables keep the whole permutation.
		write_count(17'd4);
		send_index(16'd65535, 1'b0);
		send_index(16'd3, 1'b0);
		send_index(16'd2, 1'b0);
		send_index(16'd1, 1'b0);
		send_index(16'd0, 1'b1);

		// Random part in three idle modes. Each count change waits for the block to drain,
		// which lands on mesh boundaries and in the middle of open meshes alike.
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 80 : 0;
			recv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 16 : 0;
			for (int k = 0; k < 4; k++) begin
				write_count(count_plan[mode * 4 + k]);
				if (mode == 2 && k == 0) long_hold_req = 1'b1;
				budget = (count_now < 2) ? 20 : 110;
				sent = 0;
				while (sent < budget) begin
					len = $urandom_range(40, 1);
					send_mesh(len, $urandom_range(7, 0) != 0);
					sent += len;
				end
			end
		end

		// Many tiny meshes, enough to wrap the epoch tag and force a second clearing pass
		// in the middle of traffic.
		for (int m = 0; m < 270; m++) send_mesh($urandom_range(3, 1), 1'b1);

		drain();
		repeat (20) @(negedge clk);

		$display("Run covered %0d indices in %0d meshes, %0d vertex swaps, %0d out of range.",
			index_count, mesh_count, swap_count, oor_count);
		$display("Counts ran from 0 to 131071 under both stall mixes,");
		$display("with a long result hold-off and an epoch wrap.");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
